### rtl/hsf_pkg.sv
package hsf_pkg;

	// Substitute bytes that follow the escape byte in a stuffed pair.
	localparam logic [7:0] FLAG_SUBST = 8'h5E;
	localparam logic [7:0] ESC_SUBST  = 8'h5D;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_FLAG    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 8'd3;

	// Reset values of the configuration registers.
	localparam logic [7:0] FLAG_RST    = 8'h7E;
	localparam logic [7:0] ESCAPE_RST  = 8'h7D;
	localparam logic [7:0] ADDRESS_RST = 8'h03;
	localparam logic [7:0] CONTROL_RST = 8'h00;

	// Output slots of one item, in line order.
	localparam int unsigned SLOT_N = 9;
	typedef logic [3:0] slot_t;
	typedef logic [SLOT_N-1:0] slot_mask_t;
	localparam slot_t SLOT_OPEN_FLAG = 4'd0;
	localparam slot_t SLOT_ADDRESS   = 4'd1;
	localparam slot_t SLOT_CONTROL   = 4'd2;
	localparam slot_t SLOT_HDR_CHECK = 4'd3;
	localparam slot_t SLOT_DATA_A    = 4'd4;
	localparam slot_t SLOT_DATA_B    = 4'd5;
	localparam slot_t SLOT_CHECK_A   = 4'd6;
	localparam slot_t SLOT_CHECK_B   = 4'd7;
	localparam slot_t SLOT_CLOSE     = 4'd8;

	// Configuration register bank contents.
	typedef struct packed {
		logic [7:0] flag;
		logic [7:0] escape;
		logic [7:0] address;
		logic [7:0] control;
	} cfg_t;

	// One item held between the input register and the output register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [7:0] check;
		slot_mask_t mask;
	} job_t;

	// True when a byte has to be sent as an escape pair.
	function automatic logic needs_stuff(input logic [7:0] b, input cfg_t cfg);
		return (b == cfg.flag) || (b == cfg.escape);
	endfunction

	// Second byte of an escape pair; the flag test wins when flag equals escape.
	function automatic logic [7:0] stuff_second(input logic [7:0] b, input cfg_t cfg);
		return (b == cfg.flag) ? FLAG_SUBST : ESC_SUBST;
	endfunction

endpackage

### rtl/hsf_in_if.sv
interface hsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       final_byte;

	modport source(output valid, output payload_byte, output final_byte, input ready);
	modport sink(input valid, input payload_byte, input final_byte, output ready);
endinterface

### rtl/hsf_out_if.sv
interface hsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       run_last;
	logic       frame_done;

	modport source(output valid, output line_byte, output run_last, output frame_done,
		input ready);
	modport sink(input valid, input line_byte, input run_last, input frame_done,
		output ready);
endinterface

### rtl/hsf_cfg_if.sv
interface hsf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [hsf_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/hsf_cfg_regs.sv
module hsf_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	hsf_cfg_if.sink       cfg,
	output hsf_pkg::cfg_t regs
);

	hsf_pkg::cfg_t regs_q;

	// Writes are always taken; unknown indexes are dropped.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.flag    <= hsf_pkg::FLAG_RST;
			regs_q.escape  <= hsf_pkg::ESCAPE_RST;
			regs_q.address <= hsf_pkg::ADDRESS_RST;
			regs_q.control <= hsf_pkg::CONTROL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hsf_pkg::REG_FLAG:    regs_q.flag    <= cfg.data;
				hsf_pkg::REG_ESCAPE:  regs_q.escape  <= cfg.data;
				hsf_pkg::REG_ADDRESS: regs_q.address <= cfg.data;
				hsf_pkg::REG_CONTROL: regs_q.control <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/hsf_entry.sv
module hsf_entry (
	input  logic          clk,
	input  logic          arst_n,
	hsf_in_if.sink        item_in,
	input  hsf_pkg::cfg_t regs,
	input  logic          advance,
	output hsf_pkg::job_t job
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic [7:0]          check_s1;
	hsf_pkg::slot_mask_t mask_s1;
	logic                inside_q;
	logic [7:0]          check_q;
	logic                accept;
	logic                first;
	logic                retire;
	logic [7:0]          check_new;
	hsf_pkg::slot_mask_t mask_new;
	hsf_pkg::slot_mask_t mask_rest;

	assign job = {valid_s1, data_s1, check_s1, mask_s1};

	// The held item leaves when its last slot moves to the output register.
	assign retire        = advance && $onehot(mask_s1);
	assign item_in.ready = !valid_s1 || retire;
	assign accept        = item_in.valid && item_in.ready;

	// Frame state seen by the incoming byte.
	assign first     = !inside_q;
	assign check_new = (first ? 8'h00 : check_q) ^ item_in.payload_byte;

	// Slots this item produces: header only on the first byte of a frame,
	// check and closing flag only on the final byte.
	always_comb begin
		mask_new = '0;
		mask_new[hsf_pkg::SLOT_OPEN_FLAG] = first;
		mask_new[hsf_pkg::SLOT_ADDRESS]   = first;
		mask_new[hsf_pkg::SLOT_CONTROL]   = first;
		mask_new[hsf_pkg::SLOT_HDR_CHECK] = first;
		mask_new[hsf_pkg::SLOT_DATA_A]    = 1'b1;
		mask_new[hsf_pkg::SLOT_DATA_B]    = hsf_pkg::needs_stuff(item_in.payload_byte, regs);
		mask_new[hsf_pkg::SLOT_CHECK_A]   = item_in.final_byte;
		mask_new[hsf_pkg::SLOT_CHECK_B]   = item_in.final_byte &&
			hsf_pkg::needs_stuff(check_new, regs);
		mask_new[hsf_pkg::SLOT_CLOSE]     = item_in.final_byte;
	end

	// Drop the slot just sent (the lowest one still pending).
	assign mask_rest = mask_s1 & ~(mask_s1 & (~mask_s1 + 1'b1));

	// Frame tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			check_q  <= 8'h00;
		end else if (accept) begin
			inside_q <= !item_in.final_byte;
			check_q  <= item_in.final_byte ? 8'h00 : check_new;
		end
	end

	// Input register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload and pending slots.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= item_in.payload_byte;
			check_s1 <= check_new;
			mask_s1  <= mask_new;
		end else if (advance) begin
			mask_s1  <= mask_rest;
		end
	end

endmodule

### rtl/hsf_emit.sv
module hsf_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  hsf_pkg::cfg_t regs,
	input  hsf_pkg::job_t job,
	output logic          advance,
	hsf_out_if.source     line_out
);

	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             done_q;
	hsf_pkg::slot_t   slot;
	logic [7:0]       byte_d;
	logic             done_d;

	assign line_out.valid      = valid_q;
	assign line_out.line_byte  = byte_q;
	assign line_out.run_last   = last_q;
	assign line_out.frame_done = done_q;

	// Move one byte whenever the output register is free or being emptied.
	assign advance = job.valid && (!valid_q || line_out.ready);

	// Lowest pending slot.
	always_comb begin
		slot = hsf_pkg::SLOT_CLOSE;
		for (int i = hsf_pkg::SLOT_N - 1; i >= 0; i--) begin
			if (job.mask[i]) begin
				slot = hsf_pkg::slot_t'(i);
			end
		end
	end

	// Byte for that slot.
	always_comb begin
		done_d = 1'b0;
		case (slot)
			hsf_pkg::SLOT_OPEN_FLAG: byte_d = regs.flag;
			hsf_pkg::SLOT_ADDRESS:   byte_d = regs.address;
			hsf_pkg::SLOT_CONTROL:   byte_d = regs.control;
			hsf_pkg::SLOT_HDR_CHECK: byte_d = regs.address ^ regs.control;
			hsf_pkg::SLOT_DATA_A:
				byte_d = hsf_pkg::needs_stuff(job.data, regs) ? regs.escape : job.data;
			hsf_pkg::SLOT_DATA_B:    byte_d = hsf_pkg::stuff_second(job.data, regs);
			hsf_pkg::SLOT_CHECK_A:
				byte_d = hsf_pkg::needs_stuff(job.check, regs) ? regs.escape : job.check;
			hsf_pkg::SLOT_CHECK_B:   byte_d = hsf_pkg::stuff_second(job.check, regs);
			hsf_pkg::SLOT_CLOSE: begin
				byte_d = regs.flag;
				done_d = 1'b1;
			end
			default:                 byte_d = regs.flag;
		endcase
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (line_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_d;
			last_q <= $onehot(job.mask);
			done_q <= done_d;
		end
	end

endmodule

### rtl/hdlc_style_byte_stuffing_framer_core.sv
// Byte-stuffing framer with XOR block check. Each accepted payload byte yields
// one to nine line bytes: the first byte of a frame adds flag, address, control
// and address^control ahead of it, a payload byte equal to the flag or escape
// value goes out as escape,0x5E or escape,0x5D, and the final byte adds the
// stuffed XOR of the frame's payload and a closing flag (frame_done set). The
// line side moves one byte per cycle from a single output register while it is
// ready, and an item stays in the input register until its last line byte has
// moved to the output register. The next item is taken in the cycle its
// predecessor's last byte enters the output register, so a stalled line side
// holds back at most one waiting item. Configuration writes are always taken
// and must only happen while idle.
module hdlc_style_byte_stuffing_framer_core (
	input  logic      clk,
	input  logic      arst_n,
	hsf_in_if.sink    item_in,
	hsf_out_if.source line_out,
	hsf_cfg_if.sink   cfg
);

	hsf_pkg::cfg_t regs;
	hsf_pkg::job_t job;
	logic          advance;

	// Configuration registers.
	hsf_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Input register and frame state.
	hsf_entry u_entry (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_in),
		.regs    (regs),
		.advance (advance),
		.job     (job)
	);

	// Slot selection and output register.
	hsf_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.job      (job),
		.advance  (advance),
		.line_out (line_out)
	);

endmodule

### rtl/hsf_checker.sv
module hsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] line_byte,
	input logic       run_last,
	input logic       frame_done
);

	// A stalled line byte holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_byte) && $stable(run_last)
			&& $stable(frame_done))
		else $error("line byte changed while stalled");

	// The closing flag is always the last byte of its item.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("closing flag not marked as last byte");

	// Bytes of one item follow without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside the bytes of one item");

	// Configuration writes are never stalled.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind hdlc_style_byte_stuffing_framer_core hsf_checker u_hsf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.out_valid  (line_out.valid),
	.out_ready  (line_out.ready),
	.line_byte  (line_out.line_byte),
	.run_last   (line_out.run_last),
	.frame_done (line_out.frame_done)
);
